[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STDT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define STDT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[src/stdt_pkg.sv]
package stdt_pkg;

   localparam int SECONDS_W = 32;
   localparam int YEAR_W    = 8;
   localparam int MONTH_W   = 4;
   localparam int MDAY_W    = 5;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SECOND_W  = 6;

   localparam int STAGES = 7;

   localparam logic [16:0] DAY_SECS    = 17'd86400;
   localparam logic [15:0] CYCLE_DAYS  = 16'd1461;
   localparam logic [10:0] YEAR1_START = 11'd366;
   localparam logic [10:0] YEAR2_START = 11'd731;
   localparam logic [10:0] YEAR3_START = 11'd1096;
   localparam logic [11:0] HOUR_SECS   = 12'd3600;
   localparam logic [5:0]  MINUTE_SECS = 6'd60;

   // Reciprocals for exact division by constants; each pair of
   // multiplier and shift is exact over the full operand range.
   localparam int DIV675_SHIFT = 35;
   localparam logic [25:0] RECIP_675 =
      26'(((64'd1 << DIV675_SHIFT) + 64'd674) / 64'd675);
   localparam int DIV1461_SHIFT = 27;
   localparam logic [16:0] RECIP_1461 =
      17'(((64'd1 << DIV1461_SHIFT) + 64'd1460) / 64'd1461);
   localparam int DIV3600_SHIFT = 29;
   localparam logic [17:0] RECIP_3600 =
      18'(((64'd1 << DIV3600_SHIFT) + 64'd3599) / 64'd3600);
   localparam int DIV60_SHIFT = 18;
   localparam logic [12:0] RECIP_60 =
      13'(((64'd1 << DIV60_SHIFT) + 64'd59) / 64'd60);

   localparam logic [8:0] CUM_COMMON [0:12] =
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
   localparam logic [8:0] CUM_LEAP [0:12] =
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

   typedef struct packed {
      logic [STAGES-1:0] load;
   } stdt_ctrl_type;

   function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
      logic [8:0] val;
      if (idx > 4'd12) begin
         val = 9'd0;
      end else if (leap) begin
         val = CUM_LEAP[idx];
      end else begin
         val = CUM_COMMON[idx];
      end
      return val;
   endfunction

endpackage

[src/stdt_if.sv]
interface stdt_req_if import stdt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SECONDS_W-1:0] seconds_count;

   modport source (output valid, output seconds_count, input ready);
   modport sink (input valid, input seconds_count, output ready);
endinterface

interface stdt_rsp_if import stdt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   year_offset;
   logic [MONTH_W-1:0]  month_number;
   logic [MDAY_W-1:0]   day_of_month;
   logic [HOUR_W-1:0]   hour_of_day;
   logic [MINUTE_W-1:0] minute_of_hour;
   logic [SECOND_W-1:0] second_of_minute;

   modport source (output valid, output year_offset, output month_number,
                   output day_of_month, output hour_of_day, output minute_of_hour,
                   output second_of_minute, input ready);
   modport sink (input valid, input year_offset, input month_number,
                 input day_of_month, input hour_of_day, input minute_of_hour,
                 input second_of_minute, output ready);
endinterface

[src/stdt_pipe_ctrl.sv]
module stdt_pipe_ctrl import stdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   output logic          out_valid,
   input  logic          out_ready,
   output stdt_ctrl_type ctrl
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   open;

   // A stage takes a beat when it is empty or its own beat moves on.
   always_comb begin
      open[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         open[i] = !valid_ff[i] || open[i+1];
      end
      for (int i = 0; i < STAGES; i++) begin
         if (open[i]) begin
            valid_in[i] = (i == 0) ? in_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load = open[STAGES-1:0];
   assign in_ready  = open[0];
   assign out_valid = valid_ff[STAGES-1];

endmodule

[src/stdt_day_split.sv]
module stdt_day_split import stdt_pkg::*; (
   input  logic                 clock,
   input  stdt_ctrl_type        ctrl,
   input  logic [SECONDS_W-1:0] seconds_count,
   output logic [16:0]          time_of_day,
   output logic [10:0]          day_rem,
   output logic [5:0]           cycle_count
);

   // days = floor((secs >> 7) / 675)
   logic [50:0] p1_ff, p1_in;
   logic [16:0] lo1_ff;
   logic [15:0] days_in, days_ff;
   logic [32:0] day_prod, cyc_prod_in, cyc_prod_ff;
   logic [16:0] sub2_ff, lo2_ff;
   logic [5:0]  cyc_in;
   logic [15:0] cyc_days;
   logic [16:0] tod_in, tod_ff;
   logic [10:0] rem_in, rem_ff;
   logic [5:0]  cyc_ff;

   assign p1_in = 51'(seconds_count[31:7]) * 51'(RECIP_675);

   assign days_in     = p1_ff[DIV675_SHIFT +: 16];
   assign day_prod    = 33'(days_in) * 33'(DAY_SECS);
   assign cyc_prod_in = 33'(days_in) * 33'(RECIP_1461);

   assign cyc_in   = cyc_prod_ff[DIV1461_SHIFT +: 6];
   assign cyc_days = 16'(cyc_in) * CYCLE_DAYS;
   assign rem_in   = 11'(days_ff - cyc_days);
   // time of day stays below 2^17, so the low bits of the difference suffice
   assign tod_in   = lo2_ff - sub2_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         p1_ff  <= p1_in;
         lo1_ff <= seconds_count[16:0];
      end
      if (ctrl.load[1]) begin
         days_ff     <= days_in;
         sub2_ff     <= day_prod[16:0];
         cyc_prod_ff <= cyc_prod_in;
         lo2_ff      <= lo1_ff;
      end
      if (ctrl.load[2]) begin
         tod_ff <= tod_in;
         rem_ff <= rem_in;
         cyc_ff <= cyc_in;
      end
   end

   assign time_of_day = tod_ff;
   assign day_rem     = rem_ff;
   assign cycle_count = cyc_ff;

endmodule

[src/stdt_calendar.sv]
module stdt_calendar import stdt_pkg::*; (
   input  logic                clock,
   input  stdt_ctrl_type       ctrl,
   input  logic [10:0]         day_rem,
   input  logic [5:0]          cycle_count,
   output logic [YEAR_W-1:0]   year_offset,
   output logic [MONTH_W-1:0]  month_number,
   output logic [MDAY_W-1:0]   day_of_month
);

   logic [1:0]        seg;
   logic [10:0]       base;
   logic [YEAR_W-1:0] year_in, year4_ff, year5_ff, year6_ff, year7_ff;
   logic              leap_in, leap4_ff;
   logic [8:0]        diy_in, diy4_ff;
   logic [3:0]        before_cnt;
   logic [MONTH_W-1:0] month_in, month5_ff, month6_ff, month7_ff;
   logic [MDAY_W-1:0]  mday_in, mday5_ff, mday6_ff, mday7_ff;

   // Pick the year inside the four-year cycle; the first one is leap.
   always_comb begin
      priority if (day_rem < YEAR1_START) begin
         seg  = 2'd0;
         base = 11'd0;
      end else if (day_rem < YEAR2_START) begin
         seg  = 2'd1;
         base = YEAR1_START;
      end else if (day_rem < YEAR3_START) begin
         seg  = 2'd2;
         base = YEAR2_START;
      end else begin
         seg  = 2'd3;
         base = YEAR3_START;
      end
   end

   assign year_in = YEAR_W'({cycle_count, 2'b00}) + YEAR_W'(seg);
   assign leap_in = (seg == 2'd0);
   assign diy_in  = 9'(day_rem - base);

   // Count the month starts already passed.
   always_comb begin
      before_cnt = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (diy4_ff >= cum_days(leap4_ff, 4'(m))) begin
            before_cnt = before_cnt + 4'd1;
         end
      end
   end

   assign month_in = before_cnt + 4'd1;
   assign mday_in  = MDAY_W'(diy4_ff - cum_days(leap4_ff, before_cnt) + 9'd1);

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         year4_ff <= year_in;
         leap4_ff <= leap_in;
         diy4_ff  <= diy_in;
      end
      if (ctrl.load[4]) begin
         year5_ff  <= year4_ff;
         month5_ff <= month_in;
         mday5_ff  <= mday_in;
      end
      if (ctrl.load[5]) begin
         year6_ff  <= year5_ff;
         month6_ff <= month5_ff;
         mday6_ff  <= mday5_ff;
      end
      if (ctrl.load[6]) begin
         year7_ff  <= year6_ff;
         month7_ff <= month6_ff;
         mday7_ff  <= mday6_ff;
      end
   end

   assign year_offset  = year7_ff;
   assign month_number = month7_ff;
   assign day_of_month = mday7_ff;

endmodule

[src/stdt_clock.sv]
module stdt_clock import stdt_pkg::*; (
   input  logic                clock,
   input  stdt_ctrl_type       ctrl,
   input  logic [16:0]         time_of_day,
   output logic [HOUR_W-1:0]   hour_of_day,
   output logic [MINUTE_W-1:0] minute_of_hour,
   output logic [SECOND_W-1:0] second_of_minute
);

   logic [34:0]         hprod_in, hprod_ff;
   logic [16:0]         tod4_ff;
   logic [HOUR_W-1:0]   hour_in, hour5_ff, hour6_ff, hour7_ff;
   logic [11:0]         hsub, remh_in, remh5_ff, remh6_ff;
   logic [24:0]         mprod_in, mprod_ff;
   logic [MINUTE_W-1:0] minute_in, minute7_ff;
   logic [11:0]         msub;
   logic [SECOND_W-1:0] second_in, second7_ff;

   assign hprod_in = 35'(time_of_day) * 35'(RECIP_3600);

   assign hour_in = hprod_ff[DIV3600_SHIFT +: HOUR_W];
   assign hsub    = 12'(hour_in) * HOUR_SECS;
   assign remh_in = 12'(tod4_ff) - hsub;

   assign mprod_in = 25'(remh5_ff) * 25'(RECIP_60);

   assign minute_in = mprod_ff[DIV60_SHIFT +: MINUTE_W];
   assign msub      = 12'(minute_in) * 12'(MINUTE_SECS);
   assign second_in = SECOND_W'(remh6_ff - msub);

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         hprod_ff <= hprod_in;
         tod4_ff  <= time_of_day;
      end
      if (ctrl.load[4]) begin
         hour5_ff <= hour_in;
         remh5_ff <= remh_in;
      end
      if (ctrl.load[5]) begin
         hour6_ff <= hour5_ff;
         remh6_ff <= remh5_ff;
         mprod_ff <= mprod_in;
      end
      if (ctrl.load[6]) begin
         hour7_ff   <= hour6_ff;
         minute7_ff <= minute_in;
         second7_ff <= second_in;
      end
   end

   assign hour_of_day      = hour7_ff;
   assign minute_of_hour   = minute7_ff;
   assign second_of_minute = second7_ff;

endmodule

[src/seconds_to_date_time_unit.sv]
// A response beat follows each accepted request beat through the stage registers.
// Throughput: one beat per cycle on both channels while the response side is ready.
// A stalled response holds the last stage and every full stage behind it; empty stages keep filling.
// Reset (synchronous) clears the stage valid bits; data registers keep junk.
module seconds_to_date_time_unit import stdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   stdt_req_if.sink   req_bus,
   stdt_rsp_if.source rsp_bus
);

   // Stage map:
   //   1  multiply by the reciprocal of 86400 (via 675 after a shift)
   //   2  day count ready; multiply for seconds of whole days and for 1461
   //   3  subtract: time of day, day within the four-year cycle
   //   4  year within the cycle; multiply time of day by reciprocal of 3600
   //   5  month search over the cumulative table; hour and seconds left
   //   6  multiply by reciprocal of 60
   //   7  minute and second; response register

   stdt_ctrl_type ctrl;
   logic [16:0]   time_of_day;
   logic [10:0]   day_rem;
   logic [5:0]    cycle_count;

   // Valid bits and per-stage load enables.
   stdt_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .ctrl      (ctrl)
   );

   // Split the seconds count into days, time of day and four-year cycles.
   stdt_day_split u_split (
      .clock         (clock),
      .ctrl          (ctrl),
      .seconds_count (req_bus.seconds_count),
      .time_of_day   (time_of_day),
      .day_rem       (day_rem),
      .cycle_count   (cycle_count)
   );

   // Year, month and day of month.
   stdt_calendar u_cal (
      .clock        (clock),
      .ctrl         (ctrl),
      .day_rem      (day_rem),
      .cycle_count  (cycle_count),
      .year_offset  (rsp_bus.year_offset),
      .month_number (rsp_bus.month_number),
      .day_of_month (rsp_bus.day_of_month)
   );

   // Hour, minute and second.
   stdt_clock u_clk (
      .clock            (clock),
      .ctrl             (ctrl),
      .time_of_day      (time_of_day),
      .hour_of_day      (rsp_bus.hour_of_day),
      .minute_of_hour   (rsp_bus.minute_of_hour),
      .second_of_minute (rsp_bus.second_of_minute)
   );

endmodule

[src/stdt_checker.sv]
`include "assert_macros.svh"

module stdt_checker import stdt_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [MONTH_W-1:0]  month_number,
   input logic [MDAY_W-1:0]   day_of_month,
   input logic [HOUR_W-1:0]   hour_of_day,
   input logic [MINUTE_W-1:0] minute_of_hour,
   input logic [SECOND_W-1:0] second_of_minute
);

   logic req_beat;
   logic date_ok;
   logic time_ok;

   assign req_beat = req_valid && req_ready;
   assign date_ok  = (month_number >= 4'd1) && (month_number <= 4'd12) &&
                     (day_of_month >= 5'd1);
   assign time_ok  = (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59) &&
                     (second_of_minute <= 6'd59);

   // A response beat stays offered until taken.
   `STDT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // Request side only stalls when the whole pipe is full behind a stalled output.
   `STDT_ASSERT(a_req_stall, clock, reset, !req_ready |-> rsp_valid && !rsp_ready && !req_beat)

   // Every delivered date and time is in range.
   `STDT_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> date_ok && time_ok)

   // Reset empties the pipe.
   `STDT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind seconds_to_date_time_unit stdt_checker u_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .month_number     (rsp_bus.month_number),
   .day_of_month     (rsp_bus.day_of_month),
   .hour_of_day      (rsp_bus.hour_of_day),
   .minute_of_hour   (rsp_bus.minute_of_hour),
   .second_of_minute (rsp_bus.second_of_minute)
);
